// File: src/tod_pkg.sv
// Shared constants for the tilt orientation debouncer.
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 15;
    localparam int ALPHA_W     = 16;
    localparam int MS_W        = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_AXIS_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS_MARGIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ALPHA      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_TIME_MS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_HOLD_MS       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SENSOR_AVAILABLE  = 3'd5;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] RST_MIN_AXIS_LEVEL    = 15'd1434;
    localparam logic [LEVEL_W-1:0] RST_HYSTERESIS_MARGIN = 15'd614;
    localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA      = 16'd13107;
    localparam logic [MS_W-1:0]    RST_STABLE_TIME_MS    = 16'd250;
    localparam logic [MS_W-1:0]    RST_MIN_HOLD_MS       = 16'd500;
    localparam logic               RST_SENSOR_AVAILABLE  = 1'b1;

    // Request codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_RESET  = 1'b1;

    // Orientation codes.
    localparam logic ORIENT_PORTRAIT  = 1'b0;
    localparam logic ORIENT_LANDSCAPE = 1'b1;

endpackage

`default_nettype wire

// File: src/tod_if.sv
// Handshake channel interfaces for the tilt orientation debouncer.
`timescale 1ns / 1ps
`default_nettype none

interface tod_in_if #(
    parameter int SAMPLE_WIDTH = tod_pkg::SAMPLE_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [SAMPLE_WIDTH-1:0]    accel_x;
    logic signed [SAMPLE_WIDTH-1:0]    accel_y;
    logic                              reset_orientation;
    logic [tod_pkg::TIME_W-1:0]        time_now_ms;

    modport source (
        output valid, req_type, accel_x, accel_y, reset_orientation, time_now_ms,
        input  ready
    );
    modport sink (
        input  valid, req_type, accel_x, accel_y, reset_orientation, time_now_ms,
        output ready
    );
endinterface

interface tod_out_if;
    logic valid;
    logic ready;
    logic changed;
    logic orientation;

    modport source (output valid, changed, orientation, input ready);
    modport sink (input valid, changed, orientation, output ready);
endinterface

interface tod_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tod_pkg::CFG_INDEX_W-1:0] index;
    logic [tod_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/tilt_orientation_debouncer_unit.sv
// Top level of the tilt orientation debouncer: filter, classifier and commit logic.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted word is held in an input register and, once the result register is free
// or being taken, processed by one pass of logic (one multiplier per axis, the compares
// and the commit timing) into a result register, so a new word can be taken every cycle
// while the output is not held, and each word yields exactly one result word. The filter
// and tracker registers are updated in the same cycle as the result register, which is the
// loop that sets the one-word-per-cycle rate. While a result waits at the output, the input
// register still takes one more word and then holds the input off until the result is
// taken. Configuration writes are always taken and apply to words processed afterwards.
module tilt_orientation_debouncer_unit #(
    parameter int SAMPLE_WIDTH = tod_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    tod_in_if.sink   i_in,
    tod_out_if.source o_out,
    tod_cfg_if.sink  i_cfg
);

    localparam int SW = SAMPLE_WIDTH;
    // Compare width covers both the sample magnitude and a level plus margin.
    localparam int CW = ((SW > tod_pkg::LEVEL_W) ? SW : tod_pkg::LEVEL_W) + 2;
    localparam int PW = SW + 1 + tod_pkg::ALPHA_W + 1;
    localparam int QW = PW - tod_pkg::ALPHA_W;
    localparam int RW = QW + 1;

    // Configuration registers.
    logic [tod_pkg::LEVEL_W-1:0] r_min_axis_level;
    logic [tod_pkg::LEVEL_W-1:0] r_hysteresis_margin;
    logic [tod_pkg::ALPHA_W-1:0] r_filter_alpha;
    logic [tod_pkg::MS_W-1:0]    r_stable_time_ms;
    logic [tod_pkg::MS_W-1:0]    r_min_hold_ms;
    logic                        r_sensor_available;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_axis_level    <= tod_pkg::RST_MIN_AXIS_LEVEL;
            r_hysteresis_margin <= tod_pkg::RST_HYSTERESIS_MARGIN;
            r_filter_alpha      <= tod_pkg::RST_FILTER_ALPHA;
            r_stable_time_ms    <= tod_pkg::RST_STABLE_TIME_MS;
            r_min_hold_ms       <= tod_pkg::RST_MIN_HOLD_MS;
            r_sensor_available  <= tod_pkg::RST_SENSOR_AVAILABLE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tod_pkg::REG_MIN_AXIS_LEVEL:
                    r_min_axis_level <= i_cfg.data[tod_pkg::LEVEL_W-1:0];
                tod_pkg::REG_HYSTERESIS_MARGIN:
                    r_hysteresis_margin <= i_cfg.data[tod_pkg::LEVEL_W-1:0];
                tod_pkg::REG_FILTER_ALPHA:
                    r_filter_alpha <= i_cfg.data[tod_pkg::ALPHA_W-1:0];
                tod_pkg::REG_STABLE_TIME_MS:
                    r_stable_time_ms <= i_cfg.data[tod_pkg::MS_W-1:0];
                tod_pkg::REG_MIN_HOLD_MS:
                    r_min_hold_ms <= i_cfg.data[tod_pkg::MS_W-1:0];
                tod_pkg::REG_SENSOR_AVAILABLE:
                    r_sensor_available <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    logic                          r_in_valid;
    logic                          r_req_type;
    logic signed [SW-1:0]          r_accel_x;
    logic signed [SW-1:0]          r_accel_y;
    logic                          r_reset_orientation;
    logic [tod_pkg::TIME_W-1:0]    r_time_now_ms;

    // Result register.
    logic r_out_valid;
    logic r_changed;
    logic r_orientation;

    logic do_step;
    assign do_step    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || do_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req_type          <= i_in.req_type;
            r_accel_x           <= i_in.accel_x;
            r_accel_y           <= i_in.accel_y;
            r_reset_orientation <= i_in.reset_orientation;
            r_time_now_ms       <= i_in.time_now_ms;
        end
    end

    // Tracker state.
    logic signed [SW-1:0]       r_filt_x, n_filt_x;
    logic signed [SW-1:0]       r_filt_y, n_filt_y;
    logic                       r_primed, n_primed;
    logic                       r_committed, n_committed;
    logic                       r_pending, n_pending;
    logic                       r_pending_active, n_pending_active;
    logic [tod_pkg::TIME_W-1:0] r_pending_since, n_pending_since;
    logic [tod_pkg::TIME_W-1:0] r_last_commit, n_last_commit;
    logic                       n_changed;

    // One low-pass step: filt + floor(alpha * (sample - filt) / 2^16), saturated.
    function automatic logic signed [SW-1:0] filter_step(
        input logic signed [SW-1:0]           filt,
        input logic signed [SW-1:0]           sample,
        input logic [tod_pkg::ALPHA_W-1:0]    alpha
    );
        logic signed [SW:0]                    diff;
        logic signed [tod_pkg::ALPHA_W:0]      alpha_s;
        logic signed [PW-1:0]                  prod;
        logic signed [QW-1:0]                  step;
        logic signed [RW-1:0]                  sum;
        logic signed [RW-1:0]                  max_v;
        logic signed [RW-1:0]                  min_v;
        diff    = (SW+1)'(sample) - (SW+1)'(filt);
        alpha_s = $signed({1'b0, alpha});
        prod    = PW'(diff) * PW'(alpha_s);
        step    = prod[PW-1:tod_pkg::ALPHA_W];
        sum     = RW'(filt) + RW'(step);
        max_v   = RW'({1'b0, {(SW-1){1'b1}}});
        min_v   = -RW'({1'b0, {(SW-1){1'b1}}}) - RW'(1);
        if (sum > max_v) begin
            return max_v[SW-1:0];
        end else if (sum < min_v) begin
            return min_v[SW-1:0];
        end
        return sum[SW-1:0];
    endfunction

    logic signed [SW-1:0]       step_x, step_y;
    logic [SW-1:0]              mag_x, mag_y;
    logic [CW-1:0]              ax, ay, lvl, mg;
    logic                       cand;
    logic [tod_pkg::TIME_W-1:0] since_pending, since_commit;

    always_comb begin
        n_filt_x         = r_filt_x;
        n_filt_y         = r_filt_y;
        n_primed         = r_primed;
        n_committed      = r_committed;
        n_pending        = r_pending;
        n_pending_active = r_pending_active;
        n_pending_since  = r_pending_since;
        n_last_commit    = r_last_commit;
        n_changed        = 1'b0;

        step_x = filter_step(r_filt_x, r_accel_x, r_filter_alpha);
        step_y = filter_step(r_filt_y, r_accel_y, r_filter_alpha);
        if (r_primed) begin
            n_filt_x = step_x;
            n_filt_y = step_y;
        end else begin
            n_filt_x = r_accel_x;
            n_filt_y = r_accel_y;
        end

        // Negating the most negative value wraps to itself, which reads correctly unsigned.
        mag_x = n_filt_x[SW-1] ? SW'(-n_filt_x) : SW'(n_filt_x);
        mag_y = n_filt_y[SW-1] ? SW'(-n_filt_y) : SW'(n_filt_y);
        ax    = CW'(mag_x);
        ay    = CW'(mag_y);
        lvl   = CW'(r_min_axis_level);
        mg    = CW'(r_hysteresis_margin);

        if (ax < lvl && ay < lvl) begin
            cand = r_committed;
        end else if (ax > ay + mg) begin
            cand = tod_pkg::ORIENT_PORTRAIT;
        end else if (ay > ax + mg) begin
            cand = tod_pkg::ORIENT_LANDSCAPE;
        end else begin
            cand = r_committed;
        end

        since_pending = r_time_now_ms - r_pending_since;
        since_commit  = r_time_now_ms - r_last_commit;

        if (r_req_type == tod_pkg::REQ_RESET) begin
            n_filt_x         = '0;
            n_filt_y         = '0;
            n_primed         = 1'b0;
            n_pending_active = 1'b0;
            n_committed      = r_reset_orientation;
            n_pending        = r_reset_orientation;
            n_pending_since  = r_time_now_ms;
            n_last_commit    = r_time_now_ms;
        end else if (r_sensor_available) begin
            n_primed = 1'b1;
            if (cand == r_committed) begin
                n_pending        = r_committed;
                n_pending_active = 1'b0;
            end else if (!r_pending_active || cand != r_pending) begin
                n_pending        = cand;
                n_pending_since  = r_time_now_ms;
                n_pending_active = 1'b1;
            end else if (since_pending >= tod_pkg::TIME_W'(r_stable_time_ms) &&
                         since_commit >= tod_pkg::TIME_W'(r_min_hold_ms)) begin
                n_committed      = r_pending;
                n_last_commit    = r_time_now_ms;
                n_pending_active = 1'b0;
                n_changed        = 1'b1;
            end
        end else begin
            // Sensor off: a sample leaves the filter untouched.
            n_filt_x = r_filt_x;
            n_filt_y = r_filt_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_x         <= '0;
            r_filt_y         <= '0;
            r_primed         <= 1'b0;
            r_committed      <= tod_pkg::ORIENT_PORTRAIT;
            r_pending        <= tod_pkg::ORIENT_PORTRAIT;
            r_pending_active <= 1'b0;
            r_pending_since  <= '0;
            r_last_commit    <= '0;
        end else if (do_step) begin
            r_filt_x         <= n_filt_x;
            r_filt_y         <= n_filt_y;
            r_primed         <= n_primed;
            r_committed      <= n_committed;
            r_pending        <= n_pending;
            r_pending_active <= n_pending_active;
            r_pending_since  <= n_pending_since;
            r_last_commit    <= n_last_commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_changed     <= n_changed;
            r_orientation <= n_committed;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.changed     = r_changed;
    assign o_out.orientation = r_orientation;

endmodule

`default_nettype wire
